/* hdl/rps_pkg.sv */
// Shared types and constants for the rotator position servo.
`timescale 1ns / 1ps

package rps_pkg;

  // Angle scale in tenths of a degree
  localparam logic [11:0] FULL_SCALE = 12'd3600;

  // Command codes carried in tuser
  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_GOTO = 3'd1;
  localparam logic [2:0] CMD_CW   = 3'd2;
  localparam logic [2:0] CMD_CCW  = 3'd3;
  localparam logic [2:0] CMD_STOP = 3'd4;

  // Drive actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  // Drive directions
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TICK_PERIOD = 3'd0;
  localparam logic [2:0] REG_TAPER_ZONE  = 3'd1;
  localparam logic [2:0] REG_DEADBAND    = 3'd2;
  localparam logic [2:0] REG_SOFT_LIMIT  = 3'd3;
  localparam logic [2:0] REG_FREQ_MAX    = 3'd4;
  localparam logic [2:0] REG_FREQ_MIN    = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_TICK_PERIOD = 16'd20;
  localparam logic [11:0] RST_TAPER_ZONE  = 12'd100;
  localparam logic [11:0] RST_DEADBAND    = 12'd5;
  localparam logic [10:0] RST_SOFT_LIMIT  = 11'd20;
  localparam logic [15:0] RST_FREQ_MAX    = 16'd10000;
  localparam logic [15:0] RST_FREQ_MIN    = 16'd500;

  // Taper divider widths: 12 x 16 bit product over a 12 bit zone
  localparam int unsigned DVD_W = 28;
  localparam int unsigned DVS_W = 12;
  localparam int unsigned QUO_W = 16;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_GOTO = 2'd1,
    MODE_CW   = 2'd2,
    MODE_CCW  = 2'd3
  } mode_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_MUL  = 6'b000100,
    S_LOAD = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

endpackage

/* hdl/rps_div.sv */
// Bit-serial restoring divider for the speed taper, one quotient bit per cycle.
`timescale 1ns / 1ps

module rps_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rps_pkg::DVD_W-1:0]       dividend_i,
  input  logic [rps_pkg::DVS_W-1:0]       divisor_i,
  output logic                            done_o,
  output logic [rps_pkg::QUO_W-1:0]       quot_o
);

  logic [rps_pkg::DVS_W-1:0] rem_q, rem_d;
  logic [rps_pkg::QUO_W-1:0] shf_q, shf_d;
  logic [rps_pkg::DVS_W-1:0] dvs_q;
  logic [3:0]                cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [rps_pkg::DVS_W:0]   trial;
  logic                      fits;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial = {rem_q, shf_q[rps_pkg::QUO_W-1]};
    fits  = trial >= {1'b0, dvs_q};
    if (fits) begin
      rem_d = rps_pkg::DVS_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[rps_pkg::DVS_W-1:0];
    end
    shf_d = {shf_q[rps_pkg::QUO_W-2:0], fits};
  end

  // Sequence control: sixteen steps, then flag done for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd15;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift line
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // The quotient fits 16 bits, so the upper dividend bits stay below the divisor
      rem_q <= dividend_i[rps_pkg::DVD_W-1:rps_pkg::QUO_W];
      shf_q <= dividend_i[rps_pkg::QUO_W-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      shf_q <= shf_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = shf_q;

endmodule

/* hdl/rotator_position_servo.sv */
// Top level of the rotator position servo with APB register port.
`timescale 1ns / 1ps
// Path: a request passes the evaluate and emit states into the result register;
//   a goto speed in the taper zone adds a multiply, a divider load and the
//   sixteen divider steps. The input is not ready while a request is at work,
//   and the emit state holds until the result register is free.
// Reset: asynchronous, active low; registers to their defaults, mode idle,
//   target and last tick time zero, result register empty.

module rotator_position_servo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] target_angle, [47:16] now_ms, [59:48] position, [63:60] zero
  input  logic [63:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] drive_action, [17:2] drive_freq, [18] drive_dir, [20:19] mode_now,
  // [32:21] target_now, [39:33] zero
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rps_pkg::state_e state_q, state_d;
  rps_pkg::mode_e  mode_q, mode_d;
  logic [11:0]     target_q, target_d;
  logic [31:0]     last_tick_q, last_tick_d;

  logic [15:0] tick_period_q;
  logic [11:0] taper_zone_q;
  logic [11:0] deadband_q;
  logic [10:0] soft_limit_q;
  logic [15:0] freq_max_q;
  logic [15:0] freq_min_q;

  logic [2:0]  cmd_q;
  logic [15:0] tang_q;
  logic [31:0] now_q;
  logic [11:0] pos_q;

  logic [11:0] abs_err_q, abs_err_d;
  logic [15:0] span_q, span_d;
  logic [27:0] prod_q;
  logic [1:0]  act_q, act_d;
  logic [15:0] freq_q, freq_d;
  logic        dir_q, dir_d;

  logic        out_valid_q;
  logic [39:0] out_data_q;

  logic        accept;
  logic        cfg_wr;
  logic        out_free;
  logic        div_start;
  logic        div_done;
  logic [15:0] div_quot;

  logic [31:0] elapsed;
  logic        tick_ok;
  logic [12:0] err;
  logic [11:0] abs_err;
  logic [11:0] goto_tgt;
  logic [11:0] cw_limit;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == rps_pkg::S_IDLE);
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= rps_pkg::RST_TICK_PERIOD;
      taper_zone_q  <= rps_pkg::RST_TAPER_ZONE;
      deadband_q    <= rps_pkg::RST_DEADBAND;
      soft_limit_q  <= rps_pkg::RST_SOFT_LIMIT;
      freq_max_q    <= rps_pkg::RST_FREQ_MAX;
      freq_min_q    <= rps_pkg::RST_FREQ_MIN;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        rps_pkg::REG_TICK_PERIOD: tick_period_q <= pwdata[15:0];
        rps_pkg::REG_TAPER_ZONE:  taper_zone_q  <= pwdata[11:0];
        rps_pkg::REG_DEADBAND:    deadband_q    <= pwdata[11:0];
        rps_pkg::REG_SOFT_LIMIT:  soft_limit_q  <= pwdata[10:0];
        rps_pkg::REG_FREQ_MAX:    freq_max_q    <= pwdata[15:0];
        rps_pkg::REG_FREQ_MIN:    freq_min_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[4:2])
      rps_pkg::REG_TICK_PERIOD: prdata = {16'd0, tick_period_q};
      rps_pkg::REG_TAPER_ZONE:  prdata = {20'd0, taper_zone_q};
      rps_pkg::REG_DEADBAND:    prdata = {20'd0, deadband_q};
      rps_pkg::REG_SOFT_LIMIT:  prdata = {21'd0, soft_limit_q};
      rps_pkg::REG_FREQ_MAX:    prdata = {16'd0, freq_max_q};
      rps_pkg::REG_FREQ_MIN:    prdata = {16'd0, freq_min_q};
      default:                  prdata = 32'd0;
    endcase
  end

  // Error, clamp and limit terms from the held request
  always_comb begin
    elapsed  = now_q - last_tick_q;
    tick_ok  = elapsed >= {16'd0, tick_period_q};
    err      = {1'b0, target_q} - {1'b0, pos_q};
    abs_err  = err[12] ? 12'(-err) : err[11:0];
    cw_limit = rps_pkg::FULL_SCALE - {1'b0, soft_limit_q};
    if (tang_q[15]) begin
      goto_tgt = 12'd0;
    end else if (tang_q > {4'd0, rps_pkg::FULL_SCALE}) begin
      goto_tgt = rps_pkg::FULL_SCALE;
    end else begin
      goto_tgt = tang_q[11:0];
    end
    if (freq_min_q > freq_max_q) begin
      span_d = 16'd0;
    end else begin
      span_d = freq_max_q - freq_min_q;
    end
  end

  // Sequencer: decide, then for a goto tick inside the taper zone run the taper through the serial divider
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    target_d    = target_q;
    last_tick_d = last_tick_q;
    act_d       = act_q;
    freq_d      = freq_q;
    dir_d       = dir_q;
    abs_err_d   = abs_err_q;
    div_start   = 1'b0;
    case (state_q)
      rps_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = rps_pkg::S_EVAL;
        end
      end
      rps_pkg::S_EVAL: begin
        act_d     = rps_pkg::ACT_NONE;
        freq_d    = 16'd0;
        dir_d     = rps_pkg::DIR_CW;
        abs_err_d = abs_err;
        state_d   = rps_pkg::S_EMIT;
        case (cmd_q)
          rps_pkg::CMD_GOTO: begin
            target_d = goto_tgt;
            mode_d   = rps_pkg::MODE_GOTO;
          end
          rps_pkg::CMD_CW:  mode_d = rps_pkg::MODE_CW;
          rps_pkg::CMD_CCW: mode_d = rps_pkg::MODE_CCW;
          rps_pkg::CMD_STOP: begin
            mode_d = rps_pkg::MODE_IDLE;
            act_d  = rps_pkg::ACT_STOP;
          end
          rps_pkg::CMD_TICK: begin
            if (tick_ok) begin
              last_tick_d = now_q;
              case (mode_q)
                rps_pkg::MODE_GOTO: begin
                  if (abs_err <= deadband_q) begin
                    mode_d = rps_pkg::MODE_IDLE;
                    act_d  = rps_pkg::ACT_STOP;
                  end else begin
                    act_d = rps_pkg::ACT_RUN;
                    dir_d = err[12] ? rps_pkg::DIR_CCW : rps_pkg::DIR_CW;
                    if (abs_err >= taper_zone_q) begin
                      freq_d = freq_max_q;
                    end else begin
                      state_d = rps_pkg::S_MUL;
                    end
                  end
                end
                rps_pkg::MODE_CW: begin
                  if (pos_q >= cw_limit) begin
                    mode_d = rps_pkg::MODE_IDLE;
                    act_d  = rps_pkg::ACT_STOP;
                  end else begin
                    act_d  = rps_pkg::ACT_RUN;
                    freq_d = freq_max_q;
                    dir_d  = rps_pkg::DIR_CW;
                  end
                end
                rps_pkg::MODE_CCW: begin
                  if (pos_q <= {1'b0, soft_limit_q}) begin
                    mode_d = rps_pkg::MODE_IDLE;
                    act_d  = rps_pkg::ACT_STOP;
                  end else begin
                    act_d  = rps_pkg::ACT_RUN;
                    freq_d = freq_max_q;
                    dir_d  = rps_pkg::DIR_CCW;
                  end
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase
      end
      rps_pkg::S_MUL: begin
        state_d = rps_pkg::S_LOAD;
      end
      rps_pkg::S_LOAD: begin
        div_start = 1'b1;
        state_d   = rps_pkg::S_DIV;
      end
      rps_pkg::S_DIV: begin
        if (div_done) begin
          freq_d  = freq_min_q + div_quot;
          state_d = rps_pkg::S_EMIT;
        end
      end
      rps_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = rps_pkg::S_IDLE;
        end
      end
      default: state_d = rps_pkg::S_IDLE;
    endcase
  end

  // Control state and servo state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rps_pkg::S_IDLE;
      mode_q      <= rps_pkg::MODE_IDLE;
      target_q    <= 12'd0;
      last_tick_q <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      target_q    <= target_d;
      last_tick_q <= last_tick_d;
      if (state_q == rps_pkg::S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold request fields and working values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser;
      tang_q <= s_axis_tdata[15:0];
      now_q  <= s_axis_tdata[47:16];
      pos_q  <= s_axis_tdata[59:48];
    end
    if (state_q == rps_pkg::S_EVAL) begin
      span_q <= span_d;
    end
    if (state_q == rps_pkg::S_MUL) begin
      prod_q <= 28'(abs_err_q) * 28'(span_q);
    end
    abs_err_q <= abs_err_d;
    act_q     <= act_d;
    freq_q    <= freq_d;
    dir_q     <= dir_d;
    if (state_q == rps_pkg::S_EMIT && out_free) begin
      out_data_q <= {7'd0, target_q, mode_q, dir_q, freq_q, act_q};
    end
  end

  // Serial divider for the taper quotient
  rps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (taper_zone_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // An accepted request is always evaluated next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == rps_pkg::S_EVAL)
    else $error("accepted request not evaluated");

  // The divider finishes only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == rps_pkg::S_DIV)
    else $error("divider done outside divide wait");

  // A result appears only from the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == rps_pkg::S_EMIT))
    else $error("result valid without emit");

  // A loaded result frees the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rps_pkg::S_EMIT && out_free) |=>
      (state_q == rps_pkg::S_IDLE && out_valid_q))
    else $error("emit did not load result");

  // Stored target never leaves the angle range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    target_q <= rps_pkg::FULL_SCALE)
    else $error("target out of range");

endmodule
